FILE: src/dsmrc_pkg.sv
// Shared constants and register indexes for the serial RC frame decoder.
package dsmrc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CHAN_SHIFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_MASK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HI_RES        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT     = 3'd4;

    localparam logic [2:0]  RST_CHAN_SHIFT    = 3'd3;
    localparam logic [3:0]  RST_CHAN_MASK     = 4'd7;
    localparam logic        RST_HI_RES        = 1'b1;
    localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd8;
    localparam logic [15:0] RST_GAP_LIMIT     = 16'd5000;

    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CHAN_W  = 8;
    localparam int VALUE_W = 12;
    localparam int PULSE_W = 13;
    localparam int CNT_W   = 5;
    localparam int ID_W    = 4;

    localparam logic [PULSE_W-1:0] PULSE_OFFSET  = 13'd988;
    localparam logic [PULSE_W-1:0] PULSE_DEFAULT = 13'd1500;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

endpackage

FILE: src/dsmrc_frame_mem.sv
// Frame byte store: one write port and two registered read ports.
module dsmrc_frame_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [dsmrc_pkg::BYTE_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]             raddr_a,
    input  logic [ADDR_W-1:0]             raddr_b,
    output logic [dsmrc_pkg::BYTE_W-1:0]  rdata_a,
    output logic [dsmrc_pkg::BYTE_W-1:0]  rdata_b
);
    import dsmrc_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: src/dsmrc_chan_mem.sv
// Channel value store with per-entry valid bits so unwritten entries read as zero.
module dsmrc_chan_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [dsmrc_pkg::VALUE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]             raddr,
    output logic [dsmrc_pkg::VALUE_W-1:0] rdata
);
    import dsmrc_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [VALUE_W-1:0] data_reg;
    logic               hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            hit_reg <= valid_reg[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : '0;

endmodule

FILE: src/dsm_serial_rc_frame_decoder.sv
// Top level: frame assembly, on-demand frame decode and channel readout.
//
//  Channel | Signals                      | Payload
//  --------+------------------------------+------------------------------------
//  input   | s_tvalid s_tready s_tdata    | byte or channel read, kind in tuser
//          | s_tuser                      |
//  output  | m_tvalid m_tready m_tdata    | pulse width and frame-ready flag
//  config  | cfg_we cfg_index cfg_data    | register writes, no read-back
//
// A byte transfer passes through ST_BYTE and ST_OUT; a channel read through ST_CH_RD,
// ST_CH_OUT and ST_OUT, preceded by ST_DEC when a complete frame has to be decoded
// first, one byte pair per cycle through the two frame store read ports.
// One item is worked on at a time; a finished result waits in the output
// register, and a new item is taken while it waits, up to the point the next
// result needs that register. Reset clears the channel store via valid bits.
module dsm_serial_rc_frame_decoder #(
    parameter int FRAME_BYTES  = 16,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rx_byte [7:0], time_us [39:8], channel [47:40]
    input  logic [dsmrc_pkg::IN_DATA_W-1:0]  s_tdata,
    // func [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pulse_value [12:0], frame_ready [13], zero [15:14]
    output logic [dsmrc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [dsmrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsmrc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dsmrc_pkg::*;

    localparam int POS_W  = $clog2(FRAME_BYTES);
    localparam int NPAIRS = (FRAME_BYTES - 2) / 2;
    localparam int PAIR_W = $clog2(NPAIRS + 1);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BYTE   = 3'd1;
    localparam logic [2:0] ST_DEC    = 3'd2;
    localparam logic [2:0] ST_CH_RD  = 3'd3;
    localparam logic [2:0] ST_CH_OUT = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    // Configuration registers.
    logic [2:0]  chan_shift_reg;
    logic [3:0]  chan_mask_reg;
    logic        hi_res_reg;
    logic [3:0]  channel_count_reg;
    logic [15:0] gap_limit_reg;

    // Control and frame state.
    logic [2:0]        state_reg, state_next;
    logic [POS_W-1:0]  wpos_reg, wpos_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              pending_reg, pending_next;
    logic              seen_reg, seen_next;
    logic [PAIR_W-1:0] dec_cnt_reg, dec_cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Item and result payload.
    logic              func_reg;
    logic [BYTE_W-1:0] rx_reg;
    logic [TIME_W-1:0] time_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [PULSE_W-1:0]    res_pulse_reg, res_pulse_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic              accept;
    logic [TIME_W-1:0] gap;
    logic              new_frame;
    logic [POS_W-1:0]  byte_pos;
    logic [CNT_W-1:0]  eff_count;

    logic              frm_we;
    logic [POS_W-1:0]  frm_raddr_hi, frm_raddr_lo;
    logic [BYTE_W-1:0] frm_rdata_hi, frm_rdata_lo;
    logic [BYTE_W-1:0] id_shifted;
    logic [ID_W-1:0]   pair_id;
    logic [VALUE_W-1:0] pair_value;
    logic              ch_we;
    logic [VALUE_W-1:0] ch_rdata;
    logic [PULSE_W-1:0] ch_scaled;
    logic              out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_shift_reg    <= RST_CHAN_SHIFT;
            chan_mask_reg     <= RST_CHAN_MASK;
            hi_res_reg        <= RST_HI_RES;
            channel_count_reg <= RST_CHANNEL_COUNT;
            gap_limit_reg     <= RST_GAP_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHAN_SHIFT:    chan_shift_reg    <= cfg_data[2:0];
                REG_CHAN_MASK:     chan_mask_reg     <= cfg_data[3:0];
                REG_HI_RES:        hi_res_reg        <= cfg_data[0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[3:0];
                REG_GAP_LIMIT:     gap_limit_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign eff_count = ({1'b0, channel_count_reg} > CNT_W'(MAX_CHANNELS))
                     ? CNT_W'(MAX_CHANNELS) : {1'b0, channel_count_reg};

    // Wrapping gap since the previous byte; equal to the limit continues a frame.
    assign gap       = time_reg - last_time_reg;
    assign new_frame = gap > {16'd0, gap_limit_reg};
    assign byte_pos  = new_frame ? '0 : wpos_reg;
    assign frm_we    = (state_reg == ST_BYTE);

    // Pair c sits at bytes 2c+2 (id and high bits) and 2c+3 (low byte).
    assign frm_raddr_hi = POS_W'(2 * int'(dec_cnt_reg) + 2);
    assign frm_raddr_lo = POS_W'(2 * int'(dec_cnt_reg) + 3);

    // Data for pair dec_cnt-1 arrives in the cycle after its address went out.
    assign id_shifted = frm_rdata_hi >> chan_shift_reg;
    assign pair_id    = id_shifted[ID_W-1:0];
    assign pair_value = {frm_rdata_hi[3:0] & chan_mask_reg, frm_rdata_lo};
    assign ch_we      = (state_reg == ST_DEC) && (dec_cnt_reg != '0)
                        && ({1'b0, pair_id} < eff_count);

    assign ch_scaled = hi_res_reg ? PULSE_W'(ch_rdata >> 1) : PULSE_W'(ch_rdata);

    dsmrc_frame_mem #(
        .DEPTH  (FRAME_BYTES),
        .ADDR_W (POS_W)
    ) u_frame_mem (
        .clk     (clk),
        .we      (frm_we),
        .waddr   (byte_pos),
        .wdata   (rx_reg),
        .raddr_a (frm_raddr_hi),
        .raddr_b (frm_raddr_lo),
        .rdata_a (frm_rdata_hi),
        .rdata_b (frm_rdata_lo)
    );

    dsmrc_chan_mem #(
        .DEPTH  (MAX_CHANNELS),
        .ADDR_W (CH_W)
    ) u_chan_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ch_we),
        .waddr (pair_id[CH_W-1:0]),
        .wdata (pair_value),
        .raddr (chan_reg[CH_W-1:0]),
        .rdata (ch_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        wpos_next      = wpos_reg;
        last_time_next = last_time_reg;
        pending_next   = pending_reg;
        seen_next      = seen_reg;
        dec_cnt_next   = dec_cnt_reg;
        m_tvalid_next  = m_tvalid_reg;
        res_pulse_next = res_pulse_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tuser)
                    begin
                        state_next = ST_BYTE;
                    end
                    else if (pending_reg)
                    begin
                        state_next   = ST_DEC;
                        dec_cnt_next = '0;
                    end
                    else
                    begin
                        state_next = ST_CH_RD;
                    end
                end
            end
            ST_BYTE:
            begin
                seen_next      = 1'b1;
                last_time_next = time_reg;
                res_pulse_next = '0;
                if (byte_pos == POS_W'(FRAME_BYTES - 1))
                begin
                    wpos_next    = byte_pos;
                    pending_next = 1'b1;
                end
                else
                begin
                    wpos_next = byte_pos + 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_DEC:
            begin
                if (dec_cnt_reg == PAIR_W'(NPAIRS))
                begin
                    pending_next = 1'b0;
                    state_next   = ST_CH_RD;
                end
                else
                begin
                    dec_cnt_next = dec_cnt_reg + 1'b1;
                end
            end
            ST_CH_RD:
            begin
                state_next = ST_CH_OUT;
            end
            ST_CH_OUT:
            begin
                if ((chan_reg >= {3'b000, eff_count}) || !seen_reg)
                begin
                    res_pulse_next = PULSE_DEFAULT;
                end
                else
                begin
                    res_pulse_next = PULSE_OFFSET + ch_scaled;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wpos_reg      <= '0;
            last_time_reg <= '0;
            pending_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            dec_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wpos_reg      <= wpos_next;
            last_time_reg <= last_time_next;
            pending_reg   <= pending_next;
            seen_reg      <= seen_next;
            dec_cnt_reg   <= dec_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser;
            rx_reg   <= s_tdata[7:0];
            time_reg <= s_tdata[39:8];
            chan_reg <= s_tdata[47:40];
        end
        res_pulse_reg <= res_pulse_next;
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= {2'b00, pending_reg, res_pulse_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_dec_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC) |-> pending_reg)
        else $error("frame decode running without a pending frame");

    a_dec_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC && dec_cnt_reg == PAIR_W'(NPAIRS)) |=> !pending_reg)
        else $error("pending flag survived a finished decode");

    a_byte_pulse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !func_reg) |-> (res_pulse_reg == '0))
        else $error("byte transfer produced a nonzero pulse value");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result left the holding state while the output was stalled");

    a_chan_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_we |-> ({1'b0, pair_id} < CNT_W'(MAX_CHANNELS)))
        else $error("channel store written beyond its depth");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the serial RC frame decoder: stream stimulus, pulse prediction.
module tb_top;
    import dsmrc_pkg::*;

    localparam int FRAME_N = 16;
    localparam int CHAN_N  = 8;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Index past the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] rx_byte;
        logic [TIME_W-1:0] time_us;
        logic [CHAN_W-1:0] channel;
    } rc_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_value;
        logic               frame_ready;
    } pulse_res_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // rx_byte [7:0], time_us [39:8], channel [47:40]
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    // func [0]
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // pulse_value [12:0], frame_ready [13], zero [15:14]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Decoder state as the testbench tracks it.
    logic [2:0]         rc_shift     = RST_CHAN_SHIFT;
    logic [3:0]         rc_mask      = RST_CHAN_MASK;
    logic               rc_hires     = RST_HI_RES;
    logic [3:0]         rc_count     = RST_CHANNEL_COUNT;
    logic [15:0]        rc_gap_limit = RST_GAP_LIMIT;
    logic [BYTE_W-1:0]  frame_bytes [FRAME_N];
    int                 byte_pos     = 0;
    logic [TIME_W-1:0]  last_stamp   = '0;
    logic               frame_full   = 1'b0;
    logic               byte_seen    = 1'b0;
    logic [VALUE_W-1:0] chan_value [CHAN_N];

    rc_item_t   pending_items [$];
    pulse_res_t expected_pulses [$];

    int          n_queued   = 0;
    int          n_sent     = 0;
    int          n_errors   = 0;
    int          tx_gap     = 0;
    int          rx_stall   = 0;
    int          tx_idle    = 0;
    int          rx_idle    = 0;
    bit          item_taken = 1'b0;
    logic [31:0] gen_stamp  = '0;

    dsm_serial_rc_frame_decoder #(
        .FRAME_BYTES  (FRAME_N),
        .MAX_CHANNELS (CHAN_N)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic pulse_res_t predict_pulse(input rc_item_t it);
        pulse_res_t         res;
        logic [TIME_W-1:0]  gap;
        logic [BYTE_W-1:0]  hi_shifted;
        logic [VALUE_W-1:0] val;
        int                 limit;
        int                 i;
        limit = (rc_count > CHAN_N) ? CHAN_N : int'(rc_count);
        res.pulse_value = '0;
        if (it.func == FUNC_BYTE)
        begin
            gap = it.time_us - last_stamp;
            byte_seen = 1'b1;
            last_stamp = it.time_us;
            // A gap equal to the limit still belongs to the current frame.
            if (gap > {16'd0, rc_gap_limit})
                byte_pos = 0;
            frame_bytes[byte_pos] = it.rx_byte;
            // Once full, the position sticks on the last byte and the frame stays pending.
            if (byte_pos == FRAME_N - 1)
                frame_full = 1'b1;
            else
                byte_pos++;
        end
        else
        begin
            if (frame_full)
            begin
                for (i = 3; i < FRAME_N; i += 2)
                begin
                    hi_shifted = frame_bytes[i-1] >> rc_shift;
                    if (int'(hi_shifted[3:0]) < limit)
                        chan_value[hi_shifted[2:0]] = {frame_bytes[i-1][3:0] & rc_mask,
                                                       frame_bytes[i]};
                end
                frame_full = 1'b0;
            end
            if (int'(it.channel) >= limit || !byte_seen)
                res.pulse_value = PULSE_DEFAULT;
            else
            begin
                val = chan_value[it.channel[2:0]];
                res.pulse_value = PULSE_OFFSET + (rc_hires ? {2'b0, val[11:1]} : {1'b0, val});
            end
        end
        res.frame_ready = frame_full;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < 100)
            $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 25;
            default: return 60;
        endcase
    endfunction

    // Sender: one item in flight, a random gap after each transfer.
    always @(negedge clk)
    begin : drive_items
        rc_item_t it;
        logic     valid_next;
        valid_next = s_tvalid;
        if (item_taken)
        begin
            valid_next = 1'b0;
            item_taken = 1'b0;
        end
        if (!valid_next)
        begin
            if (tx_gap > 0)
                tx_gap--;
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                s_tdata <= {it.channel, it.time_us, it.rx_byte};
                s_tuser <= it.func;
                valid_next = 1'b1;
                tx_gap = pick_gap(tx_idle);
            end
        end
        s_tvalid <= valid_next;
    end

    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_stall = pick_gap(rx_idle);
        end
    end

    always @(posedge clk)
    begin : watch_input
        rc_item_t it;
        if (rst_n && s_tvalid && s_tready)
        begin
            it.func    = s_tuser;
            it.rx_byte = s_tdata[7:0];
            it.time_us = s_tdata[39:8];
            it.channel = s_tdata[47:40];
            expected_pulses.push_back(predict_pulse(it));
            item_taken = 1'b1;
            n_sent++;
        end
    end

    always @(posedge clk)
    begin : check_output
        pulse_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pulses.size() == 0)
                report_mismatch("result with nothing pending", int'(m_tdata[12:0]), 0);
            else
            begin
                want = expected_pulses.pop_front();
                if (m_tdata[12:0] != want.pulse_value)
                    report_mismatch("pulse_value", int'(m_tdata[12:0]),
                                    int'(want.pulse_value));
                if (m_tdata[13] != want.frame_ready)
                    report_mismatch("frame_ready", int'(m_tdata[13]), int'(want.frame_ready));
                if (m_tdata[15:14] != 2'b00)
                    report_mismatch("pad bits", int'(m_tdata[15:14]), 0);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_CHAN_SHIFT:    rc_shift     = data[2:0];
            REG_CHAN_MASK:     rc_mask      = data[3:0];
            REG_HI_RES:        rc_hires     = data[0];
            REG_CHANNEL_COUNT: rc_count     = data[3:0];
            REG_GAP_LIMIT:     rc_gap_limit = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input int phase);
        logic [CFG_DATA_W-1:0] v [5];
        int                    r;
        for (r = 0; r < 5; r++)
            v[r] = CFG_DATA_W'($urandom_range(0, 65535));
        case (phase)
            1: for (r = 0; r < 5; r++) v[r] = '0;
            2: for (r = 0; r < 5; r++) v[r] = '1;
            3:
            begin
                v[0] = 16'd4;
                v[1] = 16'd15;
                v[2] = 16'd0;
                v[3] = 16'd8;
                v[4] = 16'd1;
            end
            4:
            begin
                v[0] = 16'd3;
                v[1] = 16'd7;
                v[2] = 16'd1;
                v[3] = 16'd1;
                v[4] = 16'd300;
            end
            default: ;
        endcase
        write_reg(REG_CHAN_SHIFT, v[0]);
        write_reg(REG_CHAN_MASK, v[1]);
        write_reg(REG_HI_RES, v[2]);
        write_reg(REG_CHANNEL_COUNT, v[3]);
        write_reg(REG_GAP_LIMIT, v[4]);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] stamp);
        rc_item_t it;
        it.func    = FUNC_BYTE;
        it.rx_byte = b;
        it.time_us = stamp;
        it.channel = CHAN_W'($urandom_range(0, 255));
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic push_read(input logic [CHAN_W-1:0] ch);
        rc_item_t it;
        it.func    = FUNC_READ;
        it.rx_byte = BYTE_W'($urandom_range(0, 255));
        it.time_us = $urandom;
        it.channel = ch;
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic byte_after(input logic [TIME_W-1:0] delta);
        gen_stamp += delta;
        push_byte(BYTE_W'($urandom_range(0, 255)), gen_stamp);
    endtask

    function automatic logic [TIME_W-1:0] short_delta();
        if ($urandom_range(0, 7) == 0)
            return {16'd0, rc_gap_limit};
        return $urandom_range(0, rc_gap_limit);
    endfunction

    function automatic logic [TIME_W-1:0] long_delta();
        if ($urandom_range(0, 9) == 0)
            return $urandom | 32'h0001_0000;
        return rc_gap_limit + 32'd1 + $urandom_range(0, 3000);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(0, 4) == 0)
            return CHAN_W'($urandom_range(0, 255));
        return CHAN_W'($urandom_range(0, 9));
    endfunction

    task automatic send_frame(input int nbytes);
        byte_after(long_delta());
        repeat (nbytes - 1) byte_after(short_delta());
    endtask

    task automatic directed_items();
        logic [BYTE_W-1:0] b;
        int                k;
        // Reads before any byte has arrived.
        push_read(8'd0);
        push_read(8'd255);
        // Every gap equals the limit, the first one measured from time zero.
        gen_stamp = '0;
        for (k = 0; k < FRAME_N; k++)
        begin
            b = BYTE_W'($urandom_range(0, 255));
            if (k == 2)
                b = 8'h00;
            if (k == 3 || k == 5)
                b = 8'hFF;
            if (k == 4)
                b = 8'h3F;
            gen_stamp += RST_GAP_LIMIT;
            push_byte(b, gen_stamp);
        end
        // Overwrites the last position of the full frame.
        byte_after(32'd0);
        push_read(8'd0);
        push_read(8'd7);
        push_read(8'd8);
        push_read(8'd255);
        byte_after(RST_GAP_LIMIT + 32'd1);
        push_read(8'd1);
    endtask

    task automatic gen_sequence();
        int kind;
        int k;
        if ($urandom_range(0, 7) == 0)
        begin
            tx_idle = pick_idle();
            rx_idle = pick_idle();
        end
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            send_frame(FRAME_N);
            if ($urandom_range(0, 5) == 0)
                byte_after(short_delta());
            repeat ($urandom_range(1, 5)) push_read(pick_channel());
        end
        else if (kind == 7)
        begin
            send_frame($urandom_range(1, FRAME_N - 1));
            push_read(pick_channel());
        end
        else if (kind == 8)
        begin
            // A read in the middle of a frame, then the frame is finished.
            k = $urandom_range(1, FRAME_N - 1);
            send_frame(k);
            push_read(pick_channel());
            repeat (FRAME_N - k) byte_after(short_delta());
            push_read(pick_channel());
        end
        else
        begin
            // Jump the timestamp, often to just below the wrap point.
            if ($urandom_range(0, 1) == 0)
                gen_stamp = $urandom;
            else
                gen_stamp = 32'hFFFF_FFFF - $urandom_range(0, 2 * rc_gap_limit);
            push_byte(BYTE_W'($urandom_range(0, 255)), gen_stamp);
            repeat ($urandom_range(0, FRAME_N)) byte_after(short_delta());
            push_read(pick_channel());
        end
    endtask

    task automatic wait_drained();
        while (n_sent != n_queued || expected_pulses.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int base;
        int c;
        for (c = 0; c < CHAN_N; c++)
            chan_value[c] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed_items();
        for (phase = 0; phase < 9; phase++)
        begin
            if (phase > 0)
            begin
                // Registers change only while nothing is in flight.
                wait_drained();
                apply_config(phase);
                tx_idle = pick_idle();
                rx_idle = pick_idle();
            end
            base = n_queued;
            while (n_queued - base < 130)
                gen_sequence();
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
